FILE: rtl/core/upsl_pkg.sv
// Package for the Part 2 size lookup block: sizes, field descriptor type,
// item kind codes. No dependencies.
`default_nettype none

package upsl_pkg;

    localparam int MAX_ENTRIES    = 4;
    localparam int MAX_FIELDS     = 4;
    localparam int MAX_INDEX_BITS = 8;
    localparam int PAYLOAD_BITS   = 64;

    localparam int ENT_W   = $clog2(MAX_ENTRIES);
    localparam int SLOT_W  = $clog2(MAX_FIELDS);
    localparam int DESC_N  = MAX_ENTRIES * MAX_FIELDS;
    localparam int MAP_AW  = ENT_W + MAX_INDEX_BITS;
    localparam int MAP_DEPTH = 1 << MAP_AW;
    localparam int IDX_SHW = $clog2(MAX_INDEX_BITS + 1);

    localparam int OFF_W   = 6;
    localparam int WID_W   = 4;
    localparam int LEN_W   = 7;
    localparam int VAL_W   = 12;
    localparam int SIZE_W  = 14;
    localparam int CFG_W   = 3;
    localparam int TOT_W   = $clog2(MAX_FIELDS * 15 + 1);

    localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};

    localparam logic [1:0] KIND_COMPUTE = 2'd0;
    localparam logic [1:0] KIND_DESC    = 2'd1;
    localparam logic [1:0] KIND_MAP     = 2'd2;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [WID_W-1:0] width;
    } desc_t;

    // request to the field unit
    typedef struct packed {
        desc_t                     desc;
        logic [MAX_INDEX_BITS-1:0] idx;
    } field_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/upsl_field_unit.sv
// Shared field unit: pulls one field out of the payload, first bit as MSB,
// and appends it to the running index. Depends on upsl_pkg.
`default_nettype none

module upsl_field_unit (
    input  wire logic [upsl_pkg::PAYLOAD_BITS-1:0]   bits,
    input  wire upsl_pkg::field_req_t                req,
    output logic      [upsl_pkg::MAX_INDEX_BITS-1:0] idx_out
);

    logic [upsl_pkg::PAYLOAD_BITS-1:0]   shifted;
    logic [upsl_pkg::MAX_INDEX_BITS-1:0] rev;
    logic [upsl_pkg::MAX_INDEX_BITS-1:0] fval;
    logic [upsl_pkg::IDX_SHW-1:0]        rshift;

    always_comb
    begin
        shifted = bits >> req.desc.offset;
        for (int k = 0; k < upsl_pkg::MAX_INDEX_BITS; k++)
        begin
            rev[upsl_pkg::MAX_INDEX_BITS-1-k] = shifted[k];
        end
        // widths past the index limit are flagged elsewhere; value unused then
        if (32'(req.desc.width) > upsl_pkg::MAX_INDEX_BITS)
            rshift = '0;
        else
            rshift = upsl_pkg::IDX_SHW'(upsl_pkg::MAX_INDEX_BITS - 32'(req.desc.width));
        fval    = rev >> rshift;
        idx_out = (req.idx << req.desc.width) | fval;
    end

endmodule

`default_nettype wire

FILE: rtl/core/upsl_size_map.sv
// Size-map store: one write port, one registered read port, no reset.
// Depends on upsl_pkg.
`default_nettype none

module upsl_size_map (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [upsl_pkg::MAP_AW-1:0]  wr_addr,
    input  wire logic [upsl_pkg::VAL_W-1:0]   wr_data,
    input  wire logic                         rd_en,
    input  wire logic [upsl_pkg::MAP_AW-1:0]  rd_addr,
    output logic      [upsl_pkg::VAL_W-1:0]   rd_data
);

    logic [upsl_pkg::VAL_W-1:0] mem [upsl_pkg::MAP_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/uci_part2_size_lookup.sv
// Top level of the Part 2 size lookup: sequencer, descriptor store and
// result registers. Depends on upsl_pkg, upsl_field_unit, upsl_size_map.
//
// Use:
//   An item is taken when start is high and busy is low. kind selects:
//   compute, descriptor write, map word write; kind 3 is dropped.
//   Writes complete at the accepting edge; busy stays low, so a write can
//   follow every cycle. A compute item raises busy and walks the entries in
//   use, one slot per cycle through the shared field unit, then the map
//   read of that entry. The result (part2_size, range_error) shows for one
//   cycle with done high; it is registered in S_DRAIN, which follows the
//   last entry's map read, a range error, or, with no entries in use, the
//   accepting edge. done is a strobe: the receiver cannot stall and must
//   take it then. The next item can be taken in the cycle done is shown.
//   The config channel (cfg_valid/cfg_ready/cfg_data) writes entries_in_use;
//   cfg_ready is high while idle.
//   Reset clears the descriptors and entries_in_use; map words hold
//   nothing meaningful until written.
`default_nettype none

module uci_part2_size_lookup (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [1:0]                         kind,
    input  wire logic [upsl_pkg::PAYLOAD_BITS-1:0]  part1_bits,
    input  wire logic [upsl_pkg::LEN_W-1:0]         part1_length,
    input  wire logic [1:0]                         entry_select,
    input  wire logic [1:0]                         slot_select,
    input  wire logic [upsl_pkg::OFF_W-1:0]         field_offset,
    input  wire logic [upsl_pkg::WID_W-1:0]         field_width,
    input  wire logic [7:0]                         map_address,
    input  wire logic [upsl_pkg::VAL_W-1:0]         map_value,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [upsl_pkg::CFG_W-1:0]         cfg_data,
    output logic                                    done,
    output logic      [upsl_pkg::SIZE_W-1:0]        part2_size,
    output logic                                    range_error
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FIELD = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    localparam int CNT_W = $clog2(upsl_pkg::MAX_ENTRIES + 1);

    logic [1:0]                          state_reg, state_next;
    logic [upsl_pkg::ENT_W-1:0]          ent_reg, ent_next;
    logic [upsl_pkg::SLOT_W-1:0]         slot_reg, slot_next;
    logic [upsl_pkg::MAX_INDEX_BITS-1:0] idx_reg, idx_next;
    logic [upsl_pkg::TOT_W-1:0]          total_reg, total_next;
    logic [upsl_pkg::SIZE_W-1:0]         sum_reg, sum_next;
    logic                                err_reg, err_next;
    logic                                pend_reg;
    logic [CNT_W-1:0]                    count_reg;
    logic [upsl_pkg::PAYLOAD_BITS-1:0]   bits_reg;
    logic [upsl_pkg::LEN_W-1:0]          len_reg;
    logic [upsl_pkg::CFG_W-1:0]          entries_reg;
    logic                                done_reg;
    logic [upsl_pkg::SIZE_W-1:0]         size_reg;
    logic                                rerr_reg;

    upsl_pkg::desc_t desc_reg [upsl_pkg::DESC_N];

    logic                                accept;
    logic                                desc_we;
    logic                                map_we;
    logic [CNT_W-1:0]                    count_c;
    logic [upsl_pkg::LEN_W-1:0]          len_c;
    upsl_pkg::desc_t                     cur_desc;
    upsl_pkg::field_req_t                freq;
    logic [upsl_pkg::MAX_INDEX_BITS-1:0] unit_idx;
    logic [upsl_pkg::LEN_W-1:0]          end_pos;
    logic                                field_bad;
    logic                                last_slot;
    logic                                last_ent;
    logic [upsl_pkg::VAL_W-1:0]          rd_data;
    logic [upsl_pkg::SIZE_W:0]           acc_wide;
    logic [upsl_pkg::SIZE_W-1:0]         acc_sat;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = !busy;
    assign accept    = start && !busy;
    assign desc_we   = accept && (kind == upsl_pkg::KIND_DESC)
                       && (32'(entry_select) < upsl_pkg::MAX_ENTRIES)
                       && (32'(slot_select) < upsl_pkg::MAX_FIELDS);
    assign map_we    = accept && (kind == upsl_pkg::KIND_MAP)
                       && (32'(entry_select) < upsl_pkg::MAX_ENTRIES)
                       && (32'(map_address) < (1 << upsl_pkg::MAX_INDEX_BITS));

    assign count_c = (32'(entries_reg) > upsl_pkg::MAX_ENTRIES)
                     ? CNT_W'(upsl_pkg::MAX_ENTRIES) : CNT_W'(entries_reg);
    assign len_c   = (32'(part1_length) > upsl_pkg::PAYLOAD_BITS)
                     ? upsl_pkg::LEN_W'(upsl_pkg::PAYLOAD_BITS) : part1_length;

    assign cur_desc  = desc_reg[{ent_reg, slot_reg}];
    assign freq.desc = cur_desc;
    assign freq.idx  = idx_reg;

    upsl_field_unit u_field (
        .bits    (bits_reg),
        .req     (freq),
        .idx_out (unit_idx)
    );

    upsl_size_map u_map (
        .clk     (clk),
        .wr_en   (map_we),
        .wr_addr ({entry_select[upsl_pkg::ENT_W-1:0],
                   map_address[upsl_pkg::MAX_INDEX_BITS-1:0]}),
        .wr_data (map_value),
        .rd_en   (state_reg == S_LOOK),
        .rd_addr ({ent_reg, idx_reg}),
        .rd_data (rd_data)
    );

    assign end_pos   = upsl_pkg::LEN_W'(cur_desc.offset) + upsl_pkg::LEN_W'(cur_desc.width);
    assign field_bad = end_pos > len_reg;
    assign last_slot = (32'(slot_reg) == upsl_pkg::MAX_FIELDS - 1);
    assign last_ent  = (CNT_W'(ent_reg) + CNT_W'(1)) == count_reg;

    // map word arrives the cycle after the read was issued
    always_comb
    begin
        acc_wide = {1'b0, sum_reg} + (upsl_pkg::SIZE_W + 1)'(rd_data);
        acc_sat  = (acc_wide > (upsl_pkg::SIZE_W + 1)'(upsl_pkg::SIZE_SAT))
                   ? upsl_pkg::SIZE_SAT : acc_wide[upsl_pkg::SIZE_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        ent_next   = ent_reg;
        slot_next  = slot_reg;
        idx_next   = idx_reg;
        total_next = total_reg;
        err_next   = err_reg;
        sum_next   = pend_reg ? acc_sat : sum_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (kind == upsl_pkg::KIND_COMPUTE))
                begin
                    ent_next   = '0;
                    slot_next  = '0;
                    idx_next   = '0;
                    total_next = '0;
                    err_next   = 1'b0;
                    sum_next   = '0;
                    state_next = (count_c == '0) ? S_DRAIN : S_FIELD;
                end
            end
            S_FIELD:
            begin
                total_next = total_reg + upsl_pkg::TOT_W'(cur_desc.width);
                idx_next   = unit_idx;
                if (field_bad)
                begin
                    err_next   = 1'b1;
                    state_next = S_DRAIN;
                end
                else if (last_slot)
                begin
                    if (32'(total_next) > upsl_pkg::MAX_INDEX_BITS)
                    begin
                        err_next   = 1'b1;
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        state_next = S_LOOK;
                    end
                end
                else
                begin
                    slot_next = slot_reg + upsl_pkg::SLOT_W'(1);
                end
            end
            S_LOOK:
            begin
                if (last_ent)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    ent_next   = ent_reg + upsl_pkg::ENT_W'(1);
                    slot_next  = '0;
                    idx_next   = '0;
                    total_next = '0;
                    state_next = S_FIELD;
                end
            end
            S_DRAIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pend_reg    <= 1'b0;
            done_reg    <= 1'b0;
            entries_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == S_LOOK);
            done_reg  <= (state_reg == S_DRAIN);
            if (cfg_valid && cfg_ready)
                entries_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < upsl_pkg::DESC_N; i++)
            begin
                desc_reg[i] <= '0;
            end
        end
        else if (desc_we)
        begin
            desc_reg[{entry_select[upsl_pkg::ENT_W-1:0],
                      slot_select[upsl_pkg::SLOT_W-1:0]}] <= {field_offset, field_width};
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg   <= ent_next;
        slot_reg  <= slot_next;
        idx_reg   <= idx_next;
        total_reg <= total_next;
        err_reg   <= err_next;
        sum_reg   <= sum_next;
        if (accept && (kind == upsl_pkg::KIND_COMPUTE))
        begin
            bits_reg  <= part1_bits;
            len_reg   <= len_c;
            count_reg <= count_c;
        end
        if (state_reg == S_DRAIN)
        begin
            size_reg <= err_reg ? '0 : sum_next;
            rerr_reg <= err_reg;
        end
    end

    assign done        = done_reg;
    assign part2_size  = size_reg;
    assign range_error = rerr_reg;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for uci_part2_size_lookup: a scoreboard class
// predicts every size lookup, and tasks drive descriptor, map and compute items.
// Depends on upsl_pkg and the uci_part2_size_lookup RTL.
`default_nettype none

module tb_top;
    import upsl_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 24;   // covers the longest compute, with four entries in use
    localparam int PHASE_ITEMS   = 85;

    typedef struct packed {
        logic [1:0]              kind;
        logic [PAYLOAD_BITS-1:0] bits;
        logic [LEN_W-1:0]        len;
        logic [1:0]              ent;
        logic [1:0]              slot;
        logic [OFF_W-1:0]        off;
        logic [WID_W-1:0]        wid;
        logic [7:0]              addr;
        logic [VAL_W-1:0]        val;
    } lookup_item_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              err;
    } size_result_t;

    class size_scoreboard;
        logic [OFF_W-1:0] d_off[MAX_ENTRIES][MAX_FIELDS];
        logic [WID_W-1:0] d_wid[MAX_ENTRIES][MAX_FIELDS];
        logic [VAL_W-1:0] map_word[MAX_ENTRIES][256];
        bit               map_written[MAX_ENTRIES][256];
        int unsigned      entries;
        size_result_t     pending_sizes[$];
        int               mismatches;
        int               lookups_checked;
        int               errors_seen;

        function new();
            for (int e = 0; e < MAX_ENTRIES; e++)
            begin
                for (int f = 0; f < MAX_FIELDS; f++)
                begin
                    d_off[e][f] = '0;
                    d_wid[e][f] = '0;
                end
                for (int a = 0; a < 256; a++)
                begin
                    map_word[e][a] = '0;
                    map_written[e][a] = 0;
                end
            end
            entries = 0;
            mismatches = 0;
            lookups_checked = 0;
            errors_seen = 0;
        endfunction

        // field read MSB first; positions wrap within the 64-bit payload
        function int unsigned read_bits(logic [PAYLOAD_BITS-1:0] bits, int o, int w);
            int unsigned v;
            v = 0;
            for (int k = 0; k < w; k++)
                v = (v << 1) | bits[(o + k) % 64];
            return v;
        endfunction

        // map address an entry would look up, range checks ignored
        function logic [7:0] entry_index(int e, logic [PAYLOAD_BITS-1:0] bits);
            int unsigned idx;
            idx = 0;
            for (int f = 0; f < MAX_FIELDS; f++)
                idx = ((idx << d_wid[e][f]) | read_bits(bits, d_off[e][f], d_wid[e][f]))
                      & 32'hFFFFF;
            return idx[7:0];
        endfunction

        function int active_entries();
            return (entries > MAX_ENTRIES) ? MAX_ENTRIES : entries;
        endfunction

        function size_result_t predict_size(logic [PAYLOAD_BITS-1:0] bits,
                                            logic [LEN_W-1:0] len_in);
            size_result_t r;
            int          len;
            int          total;
            int unsigned idx;
            int unsigned sum;
            bit          err;
            len = (len_in > PAYLOAD_BITS) ? PAYLOAD_BITS : int'(len_in);
            sum = 0;
            err = 0;
            for (int e = 0; e < active_entries() && !err; e++)
            begin
                idx = 0;
                total = 0;
                for (int f = 0; f < MAX_FIELDS && !err; f++)
                begin
                    // width-0 slots are range checked as well
                    if (int'(d_off[e][f]) + int'(d_wid[e][f]) > len)
                        err = 1;
                    else
                    begin
                        total += d_wid[e][f];
                        idx = ((idx << d_wid[e][f]) |
                               read_bits(bits, d_off[e][f], d_wid[e][f])) & 32'hFFFFF;
                    end
                end
                if (!err && total > MAX_INDEX_BITS)
                    err = 1;
                if (!err)
                begin
                    sum += map_word[e][idx[7:0]];
                    if (sum > 16383)
                        sum = 16383;
                end
            end
            r.size = err ? '0 : sum[SIZE_W-1:0];
            r.err  = err;
            return r;
        endfunction

        function void note_entries(logic [CFG_W-1:0] v);
            entries = v;
        endfunction

        function void note_item(lookup_item_t it);
            case (it.kind)
                KIND_DESC:
                begin
                    d_off[it.ent][it.slot] = it.off;
                    d_wid[it.ent][it.slot] = it.wid;
                end
                KIND_MAP:
                begin
                    map_word[it.ent][it.addr] = it.val;
                    map_written[it.ent][it.addr] = 1;
                end
                KIND_COMPUTE:
                    pending_sizes.push_back(predict_size(it.bits, it.len));
                default:
                    ;
            endcase
        endfunction

        function void check_result(logic [SIZE_W-1:0] size, logic err);
            size_result_t want;
            if (pending_sizes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing outstanding: size %0d error %0b",
                             size, err);
                return;
            end
            want = pending_sizes.pop_front();
            lookups_checked++;
            if (err)
                errors_seen++;
            if (size !== want.size || err !== want.err)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected size %0d error %0b, got size %0d error %0b",
                             want.size, want.err, size, err);
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [1:0]              kind = KIND_COMPUTE;
    logic [PAYLOAD_BITS-1:0] part1_bits = '0;
    logic [LEN_W-1:0]        part1_length = '0;
    logic [1:0]              entry_select = '0;
    logic [1:0]              slot_select = '0;
    logic [OFF_W-1:0]        field_offset = '0;
    logic [WID_W-1:0]        field_width = '0;
    logic [7:0]              map_address = '0;
    logic [VAL_W-1:0]        map_value = '0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_W-1:0]        cfg_data = '0;
    logic                    done;
    logic [SIZE_W-1:0]       part2_size;
    logic                    range_error;

    size_scoreboard sb;
    int desc_writes = 0;
    int map_writes = 0;
    int settings_used = 0;
    int items_sent = 0;
    int cfg_plan[10] = '{0, 7, 4, 1, 2, 3, 5, 6, 4, 7};

    uci_part2_size_lookup dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .part1_bits   (part1_bits),
        .part1_length (part1_length),
        .entry_select (entry_select),
        .slot_select  (slot_select),
        .field_offset (field_offset),
        .field_width  (field_width),
        .map_address  (map_address),
        .map_value    (map_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .done         (done),
        .part2_size   (part2_size),
        .range_error  (range_error)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(part2_size, range_error);
    end

    initial
    begin
        #1000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic lookup_item_t random_item();
        lookup_item_t it;
        it.kind = $urandom_range(0, 3);
        it.bits = {$urandom, $urandom};
        it.len  = $urandom_range(0, 127);
        it.ent  = $urandom_range(0, 3);
        it.slot = $urandom_range(0, 3);
        it.off  = $urandom_range(0, 63);
        it.wid  = $urandom_range(0, 15);
        it.addr = $urandom_range(0, 255);
        it.val  = $urandom_range(0, 4095);
        return it;
    endfunction

    task automatic drive_item(lookup_item_t it);
        @(negedge clk);
        start        = 1'b1;
        kind         = it.kind;
        part1_bits   = it.bits;
        part1_length = it.len;
        entry_select = it.ent;
        slot_select  = it.slot;
        field_offset = it.off;
        field_width  = it.wid;
        map_address  = it.addr;
        map_value    = it.val;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(it);
        items_sent++;
        if (it.kind == KIND_DESC)
            desc_writes++;
        if (it.kind == KIND_MAP)
            map_writes++;
    endtask

    task automatic idle_for(int n);
        @(negedge clk);
        start = 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // hold the sender until every lookup has reported, then let the block settle
    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending_sizes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_entries(logic [CFG_W-1:0] v);
        drain_results();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.note_entries(v);
        settings_used++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_desc(int e, int s, int o, int w);
        lookup_item_t it;
        it = random_item();
        it.kind = KIND_DESC;
        it.ent  = e;
        it.slot = s;
        it.off  = o;
        it.wid  = w;
        drive_item(it);
    endtask

    task automatic send_map(int e, int a, int v);
        lookup_item_t it;
        it = random_item();
        it.kind = KIND_MAP;
        it.ent  = e;
        it.addr = a;
        it.val  = v;
        drive_item(it);
    endtask

    // a lookup may only hit map words already loaded, so fill any gap first
    task automatic send_compute(logic [PAYLOAD_BITS-1:0] bits, int len);
        lookup_item_t it;
        logic [7:0]   a;
        for (int e = 0; e < sb.active_entries(); e++)
        begin
            a = sb.entry_index(e, bits);
            if (!sb.map_written[e][a])
                send_map(e, a, ($urandom_range(0, 3) == 0) ? 4095 : $urandom_range(0, 4095));
        end
        it = random_item();
        it.kind = KIND_COMPUTE;
        it.bits = bits;
        it.len  = len;
        drive_item(it);
    endtask

    task automatic send_noise();
        lookup_item_t it;
        it = random_item();
        it.kind = KIND_UNUSED;
        drive_item(it);
    endtask

    task automatic random_desc();
        int w;
        if ($urandom_range(0, 9) < 8)
        begin
            w = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            send_desc($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 64 - w), w);
        end
        else
            send_desc($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 63),
                      $urandom_range(0, 15));
    endtask

    task automatic random_compute();
        logic [PAYLOAD_BITS-1:0] bits;
        int r;
        int len;
        r = $urandom_range(0, 19);
        bits = (r == 0) ? '1 : (r == 1) ? '0 : {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 70)
            len = 64;
        else if (r < 80)
            len = $urandom_range(65, 127);
        else
            len = $urandom_range(0, 63);
        send_compute(bits, len);
    endtask

    initial
    begin
        int phase_start;
        int burst_left;
        int r;
        sb = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // no entries in use: result is zero whatever the payload
        send_compute('1, 127);
        send_noise();

        write_entries(1);
        send_desc(0, 0, 56, 8);           // field ends on the last payload bit
        send_compute('1, 64);
        send_compute('0, 64);
        send_compute('1, 63);             // field runs past the payload
        send_desc(0, 1, 63, 1);           // nine index bits
        send_compute('1, 64);
        send_desc(0, 0, 0, 0);
        send_desc(0, 1, 0, 0);
        send_compute({$urandom, $urandom}, 0);
        send_desc(0, 3, 63, 0);           // unused slot still range checked
        send_compute('1, 62);
        send_desc(0, 3, 0, 0);

        write_entries(7);                 // clamps to four entries
        send_desc(1, 0, 0, 8);
        send_desc(2, 0, 8, 4);
        send_desc(2, 1, 12, 4);
        for (int s = 0; s < MAX_FIELDS; s++)
            send_desc(3, s, 2 * s, 2);
        send_map(0, 0, 4095);
        for (int e = 1; e < MAX_ENTRIES; e++)
            send_map(e, 255, 4095);
        send_compute('1, 64);             // largest sum
        send_desc(1, 0, 0, 15);
        send_compute('1, 64);
        send_desc(1, 0, 0, 8);

        burst_left = 0;
        for (int ph = 0; ph < 10; ph++)
        begin
            write_entries(cfg_plan[ph]);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                if (burst_left == 0)
                begin
                    idle_for($urandom_range(1, 8));
                    burst_left = $urandom_range(1, 30);
                end
                burst_left--;
                if ($urandom_range(0, 49) == 0)
                    drain_results();
                r = $urandom_range(0, 99);
                if (r < 45)
                    random_compute();
                else if (r < 70)
                    random_desc();
                else if (r < 95)
                    send_map($urandom_range(0, 3), $urandom_range(0, 255),
                             ($urandom_range(0, 7) == 0) ? 4095 : $urandom_range(0, 4095));
                else
                    send_noise();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("checked %0d size lookups (%0d with range error) after %0d descriptor",
                 sb.lookups_checked, sb.errors_seen, desc_writes);
        $display("and %0d map writes, across %0d entry-count settings",
                 map_writes, settings_used);
        if (sb.mismatches == 0 && sb.pending_sizes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
